[sv/rrss_pkg.sv]
// ----------------------------------------------------------------------------
// Round-robin signal set: shared definitions
// Sizes, codes and the structures passed along the chain of slot cells.
// ----------------------------------------------------------------------------
`default_nettype none

package rrss_pkg;

   localparam int SLOTS      = 16;
   localparam int SIGNAL_IDS = 1024;

   localparam int ID_W     = 10;
   localparam int OPCODE_W = 2;
   localparam int STATUS_W = 2;
   localparam int COUNT_W  = $clog2(SLOTS + 1);
   localparam int SLOT_W   = (SLOTS > 1) ? $clog2(SLOTS) : 1;

   typedef logic [ID_W-1:0]     id_type;
   typedef logic [COUNT_W-1:0]  count_type;
   typedef logic [SLOT_W-1:0]   slot_index_type;

   typedef enum logic [OPCODE_W-1:0] {
      OP_ADD    = 2'd0,
      OP_REMOVE = 2'd1,
      OP_CLEAR  = 2'd2,
      OP_NEXT   = 2'd3
   } opcode_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK        = 2'd0,
      STATUS_NOT_FOUND = 2'd1,
      STATUS_FULL      = 2'd2,
      STATUS_EMPTY     = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      CELL_NONE,
      CELL_COMPARE,
      CELL_ADD,
      CELL_REMOVE,
      CELL_CLEAR
   } cell_cmd_type;

   typedef struct packed {
      cell_cmd_type   cmd;
      id_type         id;
      slot_index_type pointer;
   } cell_ctrl_type;

   typedef struct packed {
      logic           empty_seen;
      logic           hit_seen;
      logic           hi_seen;
      id_type         hi_id;
      slot_index_type hi_index;
      logic           lo_seen;
      id_type         lo_id;
      slot_index_type lo_index;
   } cell_chain_type;

endpackage

`default_nettype wire

[sv/rrss_req_if.sv]
// ----------------------------------------------------------------------------
// Round-robin signal set: request channel
// Valid/ready channel carrying one operation request.
// ----------------------------------------------------------------------------
`default_nettype none

interface rrss_req_if;

   logic                          valid;
   logic                          ready;
   logic [rrss_pkg::OPCODE_W-1:0] opcode;
   logic [rrss_pkg::ID_W-1:0]     sig_id;

   modport source (output valid, output opcode, output sig_id, input ready);
   modport sink (input valid, input opcode, input sig_id, output ready);

endinterface

`default_nettype wire

[sv/rrss_rsp_if.sv]
// ----------------------------------------------------------------------------
// Round-robin signal set: response channel
// Valid/ready channel carrying one response per request.
// ----------------------------------------------------------------------------
`default_nettype none

interface rrss_rsp_if;

   logic                          valid;
   logic                          ready;
   logic [rrss_pkg::STATUS_W-1:0] status;
   logic [rrss_pkg::ID_W-1:0]     next_id;
   logic [rrss_pkg::COUNT_W-1:0]  entry_count;

   modport source (output valid, output status, output next_id, output entry_count,
                   input ready);
   modport sink (input valid, input status, input next_id, input entry_count,
                 output ready);

endinterface

`default_nettype wire

[sv/rrss_slot_cell.sv]
// ----------------------------------------------------------------------------
// Round-robin signal set: slot cell
// Holds one identifier and its valid mark, compares against the broadcast
// identifier and extends the priority chain handed on to the next cell.
// ----------------------------------------------------------------------------
`default_nettype none

module rrss_slot_cell (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire rrss_pkg::slot_index_type slot_index,
   input  wire rrss_pkg::cell_ctrl_type  ctrl,
   input  wire rrss_pkg::cell_chain_type chain_in,
   output rrss_pkg::cell_chain_type      chain_out
);

   rrss_pkg::id_type id_ff;
   rrss_pkg::id_type id_in;
   logic             valid_ff;
   logic             valid_in;
   logic             hit_ff;
   logic             hit_in;
   logic             hi_cand;
   logic             lowest_empty;

   assign lowest_empty = !valid_ff && !chain_in.empty_seen;
   assign hi_cand      = valid_ff && (slot_index >= ctrl.pointer);

   always_comb begin
      id_in    = id_ff;
      valid_in = valid_ff;
      hit_in   = hit_ff;
      case (ctrl.cmd)
         rrss_pkg::CELL_COMPARE: begin
            hit_in = valid_ff && (id_ff == ctrl.id);
         end
         rrss_pkg::CELL_ADD: begin
            if (lowest_empty) begin
               id_in    = ctrl.id;
               valid_in = 1'b1;
            end
         end
         rrss_pkg::CELL_REMOVE: begin
            if (hit_ff) begin
               valid_in = 1'b0;
            end
         end
         rrss_pkg::CELL_CLEAR: begin
            valid_in = 1'b0;
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      chain_out            = chain_in;
      chain_out.empty_seen = chain_in.empty_seen | !valid_ff;
      chain_out.hit_seen   = chain_in.hit_seen | hit_ff;
      chain_out.hi_seen    = chain_in.hi_seen | hi_cand;
      chain_out.lo_seen    = chain_in.lo_seen | valid_ff;
      if (hi_cand && !chain_in.hi_seen) begin
         chain_out.hi_id    = id_ff;
         chain_out.hi_index = slot_index;
      end
      if (valid_ff && !chain_in.lo_seen) begin
         chain_out.lo_id    = id_ff;
         chain_out.lo_index = slot_index;
      end
   end

   always_ff @(posedge clock) begin
      id_ff <= id_in;
      if (reset) begin
         valid_ff <= 1'b0;
         hit_ff   <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         hit_ff   <= hit_in;
      end
   end

endmodule

`default_nettype wire

[sv/round_robin_signal_set_top.sv]
// ----------------------------------------------------------------------------
// Round-robin signal set: top level
// A chain of slot cells holding signal identifiers, with add, remove, clear
// and round-robin fetch of the next held identifier.
// ----------------------------------------------------------------------------
//
//   Channel    Direction  Payload
//   req_chan   in         opcode, sig_id
//   rsp_chan   out        status, next_id, entry_count
//
// Each request passes through three steps: accept, a compare step across all cells,
// and an execute step in which the cell chain resolves the lowest empty slot
// or the next occupied slot and the response register is loaded.
// The response register lets the next request be accepted while a response
// waits; the execute step holds while that earlier response is not taken.
// Reset clears all valid marks, the count and the scan pointer.
// ----------------------------------------------------------------------------
`default_nettype none

module round_robin_signal_set_top (
   input  wire logic  clock,
   input  wire logic  reset,
   rrss_req_if.sink   req_chan,
   rrss_rsp_if.source rsp_chan
);

   typedef enum logic [1:0] {
      S_IDLE,
      S_MATCH,
      S_EXEC
   } state_type;

   state_type                state_ff;
   state_type                state_in;
   rrss_pkg::opcode_type     op_ff;
   rrss_pkg::opcode_type     op_in;
   rrss_pkg::id_type         id_ff;
   rrss_pkg::id_type         id_in;
   rrss_pkg::count_type      count_ff;
   rrss_pkg::count_type      count_in;
   rrss_pkg::slot_index_type pointer_ff;
   rrss_pkg::slot_index_type pointer_in;
   logic                     rsp_valid_ff;
   logic                     rsp_valid_in;
   rrss_pkg::status_type     rsp_status_ff;
   rrss_pkg::status_type     rsp_status_in;
   rrss_pkg::id_type         rsp_next_id_ff;
   rrss_pkg::id_type         rsp_next_id_in;

   rrss_pkg::cell_ctrl_type  ctrl;
   rrss_pkg::cell_chain_type chain [rrss_pkg::SLOTS+1];
   rrss_pkg::cell_chain_type chain_end;
   rrss_pkg::slot_index_type sel_index;
   logic                     exec_go;
   logic                     id_in_range;

   assign chain[0]  = '0;
   assign chain_end = chain[rrss_pkg::SLOTS];

   for (genvar k = 0; k < rrss_pkg::SLOTS; k++) begin : g_cell
      rrss_slot_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .slot_index (rrss_pkg::slot_index_type'(k)),
         .ctrl       (ctrl),
         .chain_in   (chain[k]),
         .chain_out  (chain[k+1])
      );
   end

   assign req_chan.ready       = (state_ff == S_IDLE);
   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.status      = rsp_status_ff;
   assign rsp_chan.next_id     = rsp_next_id_ff;
   assign rsp_chan.entry_count = count_ff;

   assign exec_go     = (state_ff == S_EXEC) && (!rsp_valid_ff || rsp_chan.ready);
   assign id_in_range = (32'(id_ff) < 32'(rrss_pkg::SIGNAL_IDS));
   assign sel_index   = chain_end.hi_seen ? chain_end.hi_index : chain_end.lo_index;

   always_comb begin
      state_in       = state_ff;
      op_in          = op_ff;
      id_in          = id_ff;
      count_in       = count_ff;
      pointer_in     = pointer_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_chan.ready;
      rsp_status_in  = rsp_status_ff;
      rsp_next_id_in = rsp_next_id_ff;
      ctrl.cmd       = rrss_pkg::CELL_NONE;
      ctrl.id        = id_ff;
      ctrl.pointer   = pointer_ff;

      case (state_ff)
         S_IDLE: begin
            if (req_chan.valid) begin
               op_in    = rrss_pkg::opcode_type'(req_chan.opcode);
               id_in    = req_chan.sig_id;
               state_in = S_MATCH;
            end
         end
         S_MATCH: begin
            ctrl.cmd = rrss_pkg::CELL_COMPARE;
            state_in = S_EXEC;
         end
         S_EXEC: begin
            if (exec_go) begin
               rsp_valid_in   = 1'b1;
               rsp_status_in  = rrss_pkg::STATUS_OK;
               rsp_next_id_in = '0;
               state_in       = S_IDLE;
               case (op_ff)
                  rrss_pkg::OP_ADD: begin
                     if (!id_in_range) begin
                        rsp_status_in = rrss_pkg::STATUS_NOT_FOUND;
                     end else if (chain_end.hit_seen) begin
                        rsp_status_in = rrss_pkg::STATUS_OK;
                     end else if (chain_end.empty_seen) begin
                        ctrl.cmd = rrss_pkg::CELL_ADD;
                        count_in = count_ff + 1'b1;
                     end else begin
                        rsp_status_in = rrss_pkg::STATUS_FULL;
                     end
                  end
                  rrss_pkg::OP_REMOVE: begin
                     if (chain_end.hit_seen) begin
                        ctrl.cmd = rrss_pkg::CELL_REMOVE;
                        if (count_ff != '0) begin
                           count_in = count_ff - 1'b1;
                        end
                     end else begin
                        rsp_status_in = rrss_pkg::STATUS_NOT_FOUND;
                     end
                  end
                  rrss_pkg::OP_CLEAR: begin
                     ctrl.cmd = rrss_pkg::CELL_CLEAR;
                     count_in = '0;
                  end
                  rrss_pkg::OP_NEXT: begin
                     if ((count_ff == '0) || !(chain_end.hi_seen || chain_end.lo_seen)) begin
                        rsp_status_in = rrss_pkg::STATUS_EMPTY;
                     end else begin
                        rsp_next_id_in = chain_end.hi_seen ? chain_end.hi_id
                                                           : chain_end.lo_id;
                        if (32'(sel_index) == 32'(rrss_pkg::SLOTS - 1)) begin
                           pointer_in = '0;
                        end else begin
                           pointer_in = sel_index + 1'b1;
                        end
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      op_ff          <= op_in;
      id_ff          <= id_in;
      rsp_status_ff  <= rsp_status_in;
      rsp_next_id_ff <= rsp_next_id_in;
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         pointer_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         pointer_ff   <= pointer_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

`default_nettype wire
